// ===== design/pbt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the proportional band controller: field widths, register
// indexes, reset values and arithmetic constants. No dependencies.
package pbt_pkg;

    localparam int ADC_W      = 10;
    localparam int PERMILLE_W = 10;
    localparam int ERR_W      = 11;
    localparam int DRIVE_W    = 7;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W     = 20;
    localparam int DIVQ_W     = 15;
    localparam int STEP_W     = 5;

    typedef logic [ADC_W-1:0]      t_adc;
    typedef logic [PERMILLE_W-1:0] t_permille;
    typedef logic [ERR_W-1:0]      t_err;
    typedef logic [DRIVE_W-1:0]    t_drive;
    typedef logic [PERIOD_W-1:0]   t_period;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd2;

    localparam t_permille SETPOINT_RESET = 10'd600;
    localparam t_permille BAND_RESET     = 10'd200;
    localparam t_period   PERIOD_RESET   = 8'd10;

    localparam logic [PROD_W-1:0] ADC_FULL_SCALE = 20'd1023;
    localparam t_permille         PERMILLE_SCALE = 10'd1000;
    localparam t_drive            FULL_PERCENT   = 7'd100;
    localparam logic [STEP_W-1:0] DRIVE_STEPS    = 5'd20;

    // Dividend bits handled by the serial divider, one per cycle.
    localparam int DIV_STEPS = DIVQ_W;

endpackage

// ===== design/pbt_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the proportional band controller: one converter sample
// per item. Depends on pbt_pkg.
interface pbt_in_if import pbt_pkg::*; ();

    logic valid;
    logic ready;
    t_adc adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);

endinterface

// ===== design/pbt_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the proportional band controller: process value, error,
// drive and on/off state per item. Depends on pbt_pkg.
interface pbt_out_if import pbt_pkg::*; ();

    logic      valid;
    logic      ready;
    t_permille process_permille;
    t_err      error_permille;
    t_drive    drive_percent;
    logic      drive_on;

    modport source (output valid, output process_permille, output error_permille,
                    output drive_percent, output drive_on, input ready);
    modport sink   (input valid, input process_permille, input error_permille,
                    input drive_percent, input drive_on, output ready);

endinterface

// ===== design/proportional_band_time_pwm.sv =====
`timescale 1ns / 1ps
// Proportional band controller with time-proportioning on/off output.
// Depends on pbt_pkg, pbt_in_if and pbt_out_if.
//
// Each accepted item is one 10-bit converter sample. The block scales it to
// per mille as floor(sample*1000/1023), forms the error as setpoint minus that
// value, and turns the error into a drive of 0 to 100 percent in 5 percent
// steps across a proportional band centered on zero error. A phase counter
// that wraps at period_ticks gives the on/off output: the output is on while
// the phase is below period_ticks*drive/100, and the phase advances once per
// item. The block works on one item at a time. It multiplies the sample as
// it is taken, finishes the scaling with a correction step, forms the error,
// places the error in the band, runs the serial restoring divider that
// divides by the band width one quotient bit a cycle, and builds the result
// once the output register is free. The divider is the longest of these steps.
// The result sits in an output register, so the next item is taken while an
// earlier result still waits downstream. Configuration writes are registered
// directly and should only be issued while the block is idle.
module proportional_band_time_pwm import pbt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pbt_in_if.sink                i_in,
    pbt_out_if.source             o_out
);

    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_CORR  = 3'd2;
    localparam logic [2:0] S_ERR   = 3'd3;
    localparam logic [2:0] S_SETUP = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Configuration registers.
    t_permille r_setpoint;
    t_permille r_band;
    t_period   r_period;

    // Sequencer and working registers.
    logic [2:0]           r_state,   n_state;
    logic [PROD_W-1:0]    r_prod,    n_prod;
    t_permille            r_pv,      n_pv;
    t_err                 r_err,     n_err;
    t_permille            r_div,     n_div;
    logic [PERMILLE_W-1:0] r_rem,    n_rem;
    logic [DIVQ_W-1:0]    r_dq,      n_dq;
    logic [DIV_CNT_W-1:0] r_cnt,     n_cnt;
    logic                 r_above,   n_above;
    logic                 r_below,   n_below;
    t_period              r_phase,   n_phase;

    // Output register.
    logic      r_out_valid, n_out_valid;
    t_permille r_out_pv,    n_out_pv;
    t_err      r_out_err,   n_out_err;
    t_drive    r_out_drive, n_out_drive;
    logic      r_out_on,    n_out_on;

    logic accept;
    logic out_free;

    // Scaling: the estimate (N + N/1024)/1024 is at most one below N/1023.
    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] w_est_x;
    logic [PROD_W-1:0] w_scale_rem;

    // Band placement.
    t_permille            w_band_eff;
    logic [ERR_W:0]       w_err_ext;
    logic [ERR_W:0]       w_half_ext;
    logic [ERR_W:0]       w_offset;
    logic [DIVQ_W-1:0]    w_dividend;

    // Divider step.
    logic [PERMILLE_W:0]  w_shifted;
    logic                 w_ge;

    // Result.
    logic [STEP_W-1:0]    w_q;
    t_drive               w_drive;
    logic [PERIOD_W:0]    w_phase_inc;
    logic [13:0]          w_on_lhs;
    logic [13:0]          w_on_rhs;
    logic                 w_on;
    t_period              w_phase_next;

    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid            = r_out_valid;
    assign o_out.process_permille = r_out_pv;
    assign o_out.error_permille   = r_out_err;
    assign o_out.drive_percent    = r_out_drive;
    assign o_out.drive_on         = r_out_on;

    assign w_sum       = r_prod + (r_prod >> 10);
    assign w_est_x     = {r_pv, 10'b0} - {10'b0, r_pv};
    assign w_scale_rem = r_prod - w_est_x;

    // A band of zero behaves as a band of one.
    assign w_band_eff = (r_band == '0) ? t_permille'(1) : r_band;
    assign w_err_ext  = {r_err[ERR_W-1], r_err};
    assign w_half_ext = {3'b000, w_band_eff[PERMILLE_W-1:1]};
    assign w_offset   = w_err_ext + w_half_ext;
    assign w_dividend = (DIVQ_W'(w_offset[PERMILLE_W-1:0]) << 4)
                      + (DIVQ_W'(w_offset[PERMILLE_W-1:0]) << 2);

    assign w_shifted = {r_rem, r_dq[DIVQ_W-1]};
    assign w_ge      = w_shifted >= {1'b0, r_div};

    // Saturated cases bypass the quotient; drive is the step count times five.
    assign w_q     = r_above ? DRIVE_STEPS :
                     (r_below ? '0 : r_dq[STEP_W-1:0]);
    assign w_drive = (DRIVE_W'(w_q) << 2) + DRIVE_W'(w_q);

    // phase < floor(period*drive/100) is the same as 20*(phase+1) <= period*q.
    assign w_phase_inc  = {1'b0, r_phase} + 9'd1;
    assign w_on_lhs     = (14'(w_phase_inc) << 4) + (14'(w_phase_inc) << 2);
    assign w_on_rhs     = 14'(r_period) * 14'(w_q);
    assign w_on         = w_on_lhs <= w_on_rhs;
    assign w_phase_next = (w_phase_inc >= {1'b0, r_period}) ? '0
                                                            : w_phase_inc[PERIOD_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_prod      = r_prod;
        n_pv        = r_pv;
        n_err       = r_err;
        n_div       = r_div;
        n_rem       = r_rem;
        n_dq        = r_dq;
        n_cnt       = r_cnt;
        n_above     = r_above;
        n_below     = r_below;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pv    = r_out_pv;
        n_out_err   = r_out_err;
        n_out_drive = r_out_drive;
        n_out_on    = r_out_on;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_prod  = PROD_W'(i_in.adc_sample) * PROD_W'(PERMILLE_SCALE);
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_pv    = w_sum[PROD_W-1:10];
                n_state = S_CORR;
            end
            S_CORR: begin
                if (w_scale_rem >= ADC_FULL_SCALE) begin
                    n_pv = r_pv + t_permille'(1);
                end
                n_state = S_ERR;
            end
            S_ERR: begin
                n_err   = t_err'({1'b0, r_setpoint} - {1'b0, r_pv});
                n_state = S_SETUP;
            end
            S_SETUP: begin
                n_below = $signed(w_err_ext) < -$signed(w_half_ext);
                n_above = $signed(w_err_ext) > $signed(w_half_ext);
                n_dq    = w_dividend;
                n_rem   = '0;
                n_div   = w_band_eff;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_ge ? PERMILLE_W'(w_shifted - {1'b0, r_div})
                             : w_shifted[PERMILLE_W-1:0];
                n_dq  = {r_dq[DIVQ_W-2:0], w_ge};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pv    = r_pv;
                    n_out_err   = r_err;
                    n_out_drive = w_drive;
                    n_out_on    = w_on;
                    n_phase     = w_phase_next;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_setpoint  <= SETPOINT_RESET;
            r_band      <= BAND_RESET;
            r_period    <= PERIOD_RESET;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SETPOINT: r_setpoint <= i_cfg_data;
                    REG_BAND:     r_band     <= i_cfg_data;
                    REG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_pv        <= n_pv;
        r_err       <= n_err;
        r_div       <= n_div;
        r_rem       <= n_rem;
        r_dq        <= n_dq;
        r_cnt       <= n_cnt;
        r_above     <= n_above;
        r_below     <= n_below;
        r_out_pv    <= n_out_pv;
        r_out_err   <= n_out_err;
        r_out_drive <= n_out_drive;
        r_out_on    <= n_out_on;
    end

endmodule

// ===== design/pbt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the proportional band controller and the bind that
// attaches them to the top level. Depends on pbt_pkg.
module pbt_checker import pbt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_permille i_process_permille,
    input t_err      i_error_permille,
    input t_drive    i_drive_percent,
    input logic      i_drive_on
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_process_permille) && $stable(i_error_permille)
            && $stable(i_drive_percent) && $stable(i_drive_on))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while another is in work");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_drive_percent <= FULL_PERCENT
            && i_process_permille <= PERMILLE_SCALE)
        else $error("drive or process value out of range");

    // The output can only be on when some drive is requested.
    a_on_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_on |-> i_drive_percent != '0)
        else $error("output on with zero drive");

endmodule

bind proportional_band_time_pwm pbt_checker u_pbt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_process_permille (o_out.process_permille),
    .i_error_permille   (o_out.error_permille),
    .i_drive_percent    (o_out.drive_percent),
    .i_drive_on         (o_out.drive_on)
);
